[sv/buddy_block_allocator_macros.svh]
// assertion macros used by the buddy block allocator rtl
// depends on a clock named clock and a synchronous reset named reset in scope
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// consequent checked in the same cycle
`define BBA_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/bba_pkg.sv]
// types, constants and codes of the buddy block allocator
// no dependencies; used by every rtl file of the block
`default_nettype none

package bba_pkg;

   localparam int MAX_BLOCKS_DEF = 32;
   localparam int ORDER_W = 5;
   localparam int OWNER_W = 16;
   localparam int SIZE_W = 32;
   localparam int TOTAL_W = 6;
   localparam logic [ORDER_W-1:0] ORDER_LIMIT = 5'd31;
   localparam logic [ORDER_W-1:0] RESET_ORDER = 5'd10;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic req_type;
      logic [OWNER_W-1:0] owner_id;
      logic [SIZE_W-1:0] request_size;
   } bba_req_type;

   typedef struct packed {
      logic [OWNER_W-1:0] block_owner;
      logic [TOTAL_W-1:0] block_total;
      logic [1:0] status;
      logic last;
   } bba_rsp_type;

   typedef struct packed {
      logic [OWNER_W-1:0] owner;
      logic [ORDER_W-1:0] order;
   } bba_entry_type;

   typedef struct packed {
      logic done;
      logic [ORDER_W:0] order;
   } bba_ord_res_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SIZE,
      S_SCAN,
      S_SHIFT,
      S_FILL,
      S_PLACE,
      S_DONE,
      S_QREAD,
      S_QLOAD
   } bba_state_type;

endpackage

`default_nettype wire

[sv/bba_store.sv]
// block list memory: owner and order of each block, one write and one read port
// depends on bba_pkg for the entry type
`default_nettype none

module bba_store #(
   parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
   input  wire logic clock,
   input  wire logic wr_en,
   input  wire logic [$clog2(MAX_BLOCKS)-1:0] wr_addr,
   input  wire bba_pkg::bba_entry_type wr_data,
   input  wire logic rd_en,
   input  wire logic [$clog2(MAX_BLOCKS)-1:0] rd_addr,
   output bba_pkg::bba_entry_type rd_data
);

   bba_pkg::bba_entry_type mem[MAX_BLOCKS];
   bba_pkg::bba_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/bba_size_order.sv]
// iterative unit that rounds a request size up to a power-of-two order
// one bit of size-1 is shifted out per cycle; depends on bba_pkg
`default_nettype none

module bba_size_order (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [bba_pkg::SIZE_W-1:0] size,
   output bba_pkg::bba_ord_res_type result
);

   logic busy_ff, busy_in;
   logic [bba_pkg::SIZE_W-1:0] rem_ff, rem_in;
   logic [bba_pkg::ORDER_W:0] ord_ff, ord_in;

   always_comb begin
      busy_in = busy_ff;
      rem_in = rem_ff;
      ord_in = ord_ff;
      if (start) begin
         busy_in = 1'b1;
         // size zero rounds like size one
         rem_in = (size == '0) ? '0 : size - 1'b1;
         ord_in = '0;
      end else if (busy_ff) begin
         if (rem_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            rem_in = rem_ff >> 1;
            ord_in = ord_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      ord_ff <= ord_in;
   end

   assign result.done = busy_ff && (rem_ff == '0);
   assign result.order = ord_ff;

endmodule

`default_nettype wire

[sv/buddy_block_allocator.sv]
// buddy block allocator: sequencer, output register and configuration
// depends on bba_pkg, bba_store, bba_size_order and the assertion macros
//
// usage:
//  req channel (valid/ready) carries an allocate or a query item. req_ready is
//  high only while the sequencer is idle; one item is worked at a time.
//  allocate: the size order unit rounds the size up to an order, one scan of
//  the list reads every block, a split moves the tail of the list one entry a
//  cycle and writes one new block a cycle. It gives one rsp item with status
//  and last.
//  query: one rsp item per block, leftmost first; a block is read, then its
//  item is loaded while the receiver keeps up; last marks the final block.
//  the list memory has one read and one write port, which sets the pace.
//  rsp is held in an output register; a stalled receiver holds the sequencer
//  when it has its next item ready, and a new req item can be taken while the
//  final item of the previous one still waits.
//  csr_we writes total_order and resets the list to one free block at once.
//  reset: list holds one free block of order 10; the entry write happens in
//  the reset cycle itself, so the block is ready right after reset.
`default_nettype none
`include "buddy_block_allocator_macros.svh"

module buddy_block_allocator #(
   parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire bba_pkg::bba_req_type req_data,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output bba_pkg::bba_rsp_type rsp_data,
   input  wire logic csr_we,
   input  wire logic [bba_pkg::ORDER_W-1:0] csr_data
);

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int SUM_W = CNT_W + bba_pkg::ORDER_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

   bba_pkg::bba_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0] pipe_idx_ff, pipe_idx_in;
   logic best_vld_ff, best_vld_in;
   logic [bba_pkg::ORDER_W-1:0] best_ord_ff, best_ord_in;
   logic [IDX_W-1:0] best_pos_ff, best_pos_in;
   logic [bba_pkg::ORDER_W-1:0] target_ff, target_in;
   logic [bba_pkg::ORDER_W-1:0] dist_ff, dist_in;
   logic [bba_pkg::ORDER_W-1:0] fill_ff, fill_in;
   logic [bba_pkg::OWNER_W-1:0] owner_ff, owner_in;
   logic [1:0] status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;
   bba_pkg::bba_rsp_type rsp_data_ff, rsp_data_in;

   logic req_accept;
   logic slot_free;
   logic rsp_load;
   logic hit;
   logic [bba_pkg::ORDER_W-1:0] gap;
   logic [SUM_W-1:0] grown;

   logic rd_en;
   logic [IDX_W-1:0] rd_addr;
   bba_pkg::bba_entry_type rd_data;
   logic fsm_we;
   logic [IDX_W-1:0] fsm_waddr;
   bba_pkg::bba_entry_type fsm_wdata;
   logic wr_en;
   logic [IDX_W-1:0] wr_addr;
   bba_pkg::bba_entry_type wr_data;

   bba_pkg::bba_ord_res_type ord_res;

   bba_size_order u_size_order (
      .clock  (clock),
      .reset  (reset),
      .start  (req_accept && (req_data.req_type == bba_pkg::REQ_ALLOC)),
      .size   (req_data.request_size),
      .result (ord_res)
   );

   bba_store #(
      .MAX_BLOCKS(MAX_BLOCKS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == bba_pkg::S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // reset and csr writes re-seed entry zero with one free block
   always_comb begin
      wr_en = fsm_we;
      wr_addr = fsm_waddr;
      wr_data = fsm_wdata;
      if (reset) begin
         wr_en = 1'b1;
         wr_addr = '0;
         wr_data = '{owner: '0, order: bba_pkg::RESET_ORDER};
      end else if (csr_we) begin
         wr_en = 1'b1;
         wr_addr = '0;
         wr_data = '{owner: '0, order: csr_data};
      end
   end

   // scan compare: free block no smaller than target, strictly better than best
   assign hit = pipe_vld_ff && (rd_data.owner == '0) && (rd_data.order >= target_ff)
                && (!best_vld_ff || (rd_data.order < best_ord_ff));
   assign gap = best_ord_ff - target_ff;
   assign grown = SUM_W'(cnt_ff) + SUM_W'(gap);

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      pipe_vld_in = 1'b0;
      pipe_idx_in = pipe_idx_ff;
      best_vld_in = best_vld_ff;
      best_ord_in = best_ord_ff;
      best_pos_in = best_pos_ff;
      target_in = target_ff;
      dist_in = dist_ff;
      fill_in = fill_ff;
      owner_in = owner_ff;
      status_in = status_ff;
      rsp_load = 1'b0;
      rsp_data_in = rsp_data_ff;
      rd_en = 1'b0;
      rd_addr = '0;
      fsm_we = 1'b0;
      fsm_waddr = '0;
      fsm_wdata = '{owner: '0, order: '0};

      case (state_ff)
         bba_pkg::S_IDLE: begin
            if (req_accept) begin
               owner_in = req_data.owner_id;
               idx_in = '0;
               if (req_data.req_type == bba_pkg::REQ_QUERY) begin
                  state_in = bba_pkg::S_QREAD;
               end else begin
                  state_in = bba_pkg::S_SIZE;
               end
            end
         end
         bba_pkg::S_SIZE: begin
            if (ord_res.done) begin
               if (ord_res.order > {1'b0, bba_pkg::ORDER_LIMIT}) begin
                  status_in = bba_pkg::ST_NOFIT;
                  state_in = bba_pkg::S_DONE;
               end else begin
                  target_in = ord_res.order[bba_pkg::ORDER_W-1:0];
                  best_vld_in = 1'b0;
                  idx_in = '0;
                  state_in = bba_pkg::S_SCAN;
               end
            end
         end
         bba_pkg::S_SCAN: begin
            if (idx_ff < cnt_ff) begin
               rd_en = 1'b1;
               rd_addr = idx_ff[IDX_W-1:0];
               idx_in = idx_ff + 1'b1;
               pipe_vld_in = 1'b1;
               pipe_idx_in = idx_ff[IDX_W-1:0];
            end
            if (hit) begin
               best_vld_in = 1'b1;
               best_ord_in = rd_data.order;
               best_pos_in = pipe_idx_ff;
            end
            if ((idx_ff >= cnt_ff) && !pipe_vld_ff) begin
               dist_in = gap;
               fill_in = 5'd1;
               if (!best_vld_ff) begin
                  status_in = bba_pkg::ST_NOFIT;
                  state_in = bba_pkg::S_DONE;
               end else if (grown > SUM_W'(MAX_BLOCKS)) begin
                  status_in = bba_pkg::ST_FULL;
                  state_in = bba_pkg::S_DONE;
               end else if (gap == '0) begin
                  state_in = bba_pkg::S_PLACE;
               end else begin
                  idx_in = cnt_ff - 1'b1;
                  state_in = bba_pkg::S_SHIFT;
               end
            end
         end
         bba_pkg::S_SHIFT: begin
            // tail moves right by dist, each entry written in the cycle after its read
            if (idx_ff > CNT_W'(best_pos_ff)) begin
               rd_en = 1'b1;
               rd_addr = idx_ff[IDX_W-1:0];
               idx_in = idx_ff - 1'b1;
               pipe_vld_in = 1'b1;
               pipe_idx_in = idx_ff[IDX_W-1:0] + IDX_W'(dist_ff);
            end
            if (pipe_vld_ff) begin
               fsm_we = 1'b1;
               fsm_waddr = pipe_idx_ff;
               fsm_wdata = rd_data;
            end
            if ((idx_ff <= CNT_W'(best_pos_ff)) && !pipe_vld_ff) begin
               state_in = bba_pkg::S_FILL;
            end
         end
         bba_pkg::S_FILL: begin
            // free right halves, smallest next to the placed block
            fsm_we = 1'b1;
            fsm_waddr = best_pos_ff + IDX_W'(fill_ff);
            fsm_wdata = '{owner: '0, order: target_ff + fill_ff - 1'b1};
            fill_in = fill_ff + 1'b1;
            if (fill_ff == dist_ff) begin
               state_in = bba_pkg::S_PLACE;
            end
         end
         bba_pkg::S_PLACE: begin
            fsm_we = 1'b1;
            fsm_waddr = best_pos_ff;
            fsm_wdata = '{owner: owner_ff, order: target_ff};
            cnt_in = cnt_ff + CNT_W'(dist_ff);
            status_in = bba_pkg::ST_OK;
            state_in = bba_pkg::S_DONE;
         end
         bba_pkg::S_DONE: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               rsp_data_in = '{block_owner: '0,
                               block_total: bba_pkg::TOTAL_W'(cnt_ff),
                               status: status_ff,
                               last: 1'b1};
               state_in = bba_pkg::S_IDLE;
            end
         end
         bba_pkg::S_QREAD: begin
            rd_en = 1'b1;
            rd_addr = idx_ff[IDX_W-1:0];
            state_in = bba_pkg::S_QLOAD;
         end
         bba_pkg::S_QLOAD: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               rsp_data_in = '{block_owner: rd_data.owner,
                               block_total: bba_pkg::TOTAL_W'(cnt_ff),
                               status: bba_pkg::ST_OK,
                               last: (idx_ff + 1'b1 == cnt_ff)};
               idx_in = idx_ff + 1'b1;
               if (idx_ff + 1'b1 == cnt_ff) begin
                  state_in = bba_pkg::S_IDLE;
               end else begin
                  state_in = bba_pkg::S_QREAD;
               end
            end
         end
         default: begin
            state_in = bba_pkg::S_IDLE;
         end
      endcase

      if (csr_we) begin
         cnt_in = CNT_W'(1);
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bba_pkg::S_IDLE;
         cnt_ff <= CNT_W'(1);
         pipe_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         pipe_vld_ff <= pipe_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      pipe_idx_ff <= pipe_idx_in;
      best_vld_ff <= best_vld_in;
      best_ord_ff <= best_ord_in;
      best_pos_ff <= best_pos_in;
      target_ff <= target_in;
      dist_ff <= dist_in;
      fill_ff <= fill_in;
      owner_ff <= owner_in;
      status_ff <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   `BBA_ASSERT_SAME(a_cnt_range, 1'b1,
      (cnt_ff != '0) && (cnt_ff <= CNT_MAX), "block count out of range")
   `BBA_ASSERT_SAME(a_shift_dest, (state_ff == bba_pkg::S_SHIFT) && pipe_vld_ff,
      pipe_idx_ff > best_pos_ff, "shift writes over the split block")
   `BBA_ASSERT_SAME(a_fill_range, state_ff == bba_pkg::S_FILL,
      (fill_ff != '0) && (fill_ff <= dist_ff), "fill index outside split range")
   `BBA_ASSERT_NEXT(a_last_idle, rsp_load && rsp_data_in.last,
      state_ff == bba_pkg::S_IDLE, "sequencer busy after final item")

endmodule

`default_nettype wire
